[hdl/utc_date_time_to_epoch_ms_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros for the utc date/time to epoch ms block
// ----------------------------------------------------------------------------
`ifndef UTC_DATE_TIME_TO_EPOCH_MS_MACROS_SVH
`define UTC_DATE_TIME_TO_EPOCH_MS_MACROS_SVH

// antecedent implies consequent on the same edge
`define UTC_ASSERT_IMP(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error(msg);

// antecedent implies consequent a fixed number of edges later
`define UTC_ASSERT_DLY(lbl, clk, rst_n, a, n, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> ##n (c)) \
        else $error(msg);

`endif

[hdl/utc_pkg.sv]
// ----------------------------------------------------------------------------
// utc_pkg
// shared types, constants and calendar tables for the epoch ms converter
// ----------------------------------------------------------------------------
package utc_pkg;

    // pipeline shape
    localparam int C_STEPS   = 5;
    localparam int C_LATENCY = 15;

    // month numbers
    localparam logic [3:0] C_JAN = 4'd1;
    localparam logic [3:0] C_FEB = 4'd2;
    localparam logic [3:0] C_APR = 4'd4;
    localparam logic [3:0] C_JUN = 4'd6;
    localparam logic [3:0] C_SEP = 4'd9;
    localparam logic [3:0] C_NOV = 4'd11;
    localparam logic [3:0] C_DEC = 4'd12;

    localparam logic [5:0]        C_LAST_MINUTE = 6'd59;
    localparam logic [4:0]        C_LAST_HOUR   = 5'd23;
    localparam logic signed [19:0] C_MS_PER_MIN = 20'sd60000;
    localparam logic [9:0]        C_MS_PER_SEC  = 10'd1000;
    localparam logic [14:0]       C_EPOCH_YEAR  = 15'd1970;

    // divisibility by 25 through the inverse of 25 modulo 2^14
    localparam logic [12:0] C_INV25     = 13'd7209;
    localparam logic [13:0] C_INV25_LIM = 14'd655;

    // reciprocals: floor(x/1000) for x < 2^16, floor(x/400) for x < 2^15
    localparam logic [16:0] C_RECIP_1000 = 17'd67109;
    localparam logic [15:0] C_RECIP_400  = 16'd41944;

    localparam logic [8:0]  C_YEARS_PER_ERA = 9'd400;
    localparam logic [17:0] C_DAYS_PER_ERA  = 18'd146097;
    localparam logic [19:0] C_EPOCH_DAY_OFS = 20'd719468;
    localparam logic [8:0]  C_DAYS_PER_YEAR = 9'd365;
    localparam logic [16:0] C_SEC_PER_DAY   = 17'd86400;
    localparam logic [11:0] C_SEC_PER_HOUR  = 12'd3600;
    localparam logic [5:0]  C_SEC_PER_MIN   = 6'd60;

    typedef struct packed {
        logic [14:0]        year;
        logic [3:0]         month;
        logic [4:0]         day;
        logic [4:0]         hour;
        logic [5:0]         minute;
        logic signed [19:0] total;
        logic               leap;
        logic               under;
        logic               bad_month;
        logic [16:0]        millis_raw;
    } t_item;

    function automatic logic [4:0] f_mdays(input logic leap, input logic [3:0] month);
        logic [4:0] len;
        case (month) inside
            C_FEB:                      len = leap ? 5'd29 : 5'd28;
            C_APR, C_JUN, C_SEP, C_NOV: len = 5'd30;
            default:                    len = 5'd31;
        endcase
        return len;
    endfunction

    // day offset of a march-based month, (153*mp+2)/5
    function automatic logic [8:0] f_doy_base(input logic [3:0] mp);
        logic [8:0] base;
        case (mp)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd61;
            4'd3:    base = 9'd92;
            4'd4:    base = 9'd122;
            4'd5:    base = 9'd153;
            4'd6:    base = 9'd184;
            4'd7:    base = 9'd214;
            4'd8:    base = 9'd245;
            4'd9:    base = 9'd275;
            4'd10:   base = 9'd306;
            4'd11:   base = 9'd337;
            default: base = 9'd0;
        endcase
        return base;
    endfunction

endpackage

[hdl/utc_date_time_to_epoch_ms.sv]
// ----------------------------------------------------------------------------
// utc_date_time_to_epoch_ms
// utc calendar date and time with signed ms offset to unix epoch ms
// ----------------------------------------------------------------------------
// A conversion starts at any clock edge where start is high and busy is low;
// busy is high only while reset is held, so a new conversion may start every
// cycle. Each result appears after its start transfer, for one cycle with
// o_done high, and cannot be held off by the receiver. The pipeline has one
// input stage, five single-minute carry stages and nine stages of day and
// millisecond arithmetic. o_valid_res low means the date was rejected and
// o_epoch_ms is zero.
`include "utc_date_time_to_epoch_ms_macros.svh"

module utc_date_time_to_epoch_ms (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [13:0]        i_year,
    input  logic [3:0]         i_month,
    input  logic [4:0]         i_day,
    input  logic [4:0]         i_hour,
    input  logic [5:0]         i_minute,
    input  logic [7:0]         i_second,
    input  logic signed [16:0] i_millis,
    output logic [47:0]        o_epoch_ms,
    output logic signed [16:0] o_frac_ms,
    output logic               o_valid_res,
    output logic               o_done
);
    import utc_pkg::*;

    logic           w_accept;
    logic [C_STEPS:0] w_stage_valid;
    t_item          w_stage_item [0:C_STEPS];
    logic           w_res_ok;
    logic           w_res_bad;
    logic           w_ms_ok;

    assign busy     = !i_rst_n;
    assign w_accept = start && !busy;

    utc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_accept),
        .i_year   (i_year),
        .i_month  (i_month),
        .i_day    (i_day),
        .i_hour   (i_hour),
        .i_minute (i_minute),
        .i_second (i_second),
        .i_millis (i_millis),
        .o_valid  (w_stage_valid[0]),
        .o_item   (w_stage_item[0])
    );

    // up to five minute carries or two borrows bring the total into range
    for (genvar g = 0; g < C_STEPS; g++) begin : g_step
        utc_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_stage_valid[g]),
            .i_item  (w_stage_item[g]),
            .o_valid (w_stage_valid[g+1]),
            .o_item  (w_stage_item[g+1])
        );
    end

    utc_conv u_conv (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_stage_valid[C_STEPS]),
        .i_item      (w_stage_item[C_STEPS]),
        .o_done      (o_done),
        .o_epoch_ms  (o_epoch_ms),
        .o_frac_ms   (o_frac_ms),
        .o_valid_res (o_valid_res)
    );

    assign w_res_ok  = o_done && o_valid_res;
    assign w_res_bad = o_done && !o_valid_res;
    assign w_ms_ok   = !o_frac_ms[16] && (o_frac_ms < 17'sd1000);

    `UTC_ASSERT_DLY(a_start_gives_done, i_clk, i_rst_n, w_accept, C_LATENCY, o_done, "no result")
    `UTC_ASSERT_IMP(a_done_start, i_clk, i_rst_n, o_done, $past(w_accept, C_LATENCY), "no start")
    `UTC_ASSERT_IMP(a_reject_is_zero, i_clk, i_rst_n, w_res_bad, o_epoch_ms == '0, "nonzero")
    `UTC_ASSERT_IMP(a_ms_in_range, i_clk, i_rst_n, w_res_ok, w_ms_ok, "ms out of range")

endmodule

[hdl/utc_front.sv]
// ----------------------------------------------------------------------------
// utc_front
// input stage: folds seconds into a signed ms total, flags leap year and
// invalid month
// ----------------------------------------------------------------------------
module utc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [13:0]        i_year,
    input  logic [3:0]         i_month,
    input  logic [4:0]         i_day,
    input  logic [4:0]         i_hour,
    input  logic [5:0]         i_minute,
    input  logic [7:0]         i_second,
    input  logic signed [16:0] i_millis,
    output logic               o_valid,
    output utc_pkg::t_item     o_item
);
    import utc_pkg::*;

    logic [17:0] n_sec_ms;
    logic [26:0] n_year_prod;
    logic        n_div25;
    t_item       n_item;
    logic        r_valid;
    t_item       r_item;

    always_comb begin
        n_sec_ms    = 18'(i_second) * 18'(C_MS_PER_SEC);
        n_year_prod = 27'(i_year) * 27'(C_INV25);
        n_div25     = n_year_prod[13:0] <= C_INV25_LIM;

        n_item            = '0;
        n_item.year       = 15'(i_year);
        n_item.month      = i_month;
        n_item.day        = i_day;
        n_item.hour       = i_hour;
        n_item.minute     = i_minute;
        n_item.total      = $signed({2'b00, n_sec_ms}) + 20'(i_millis);
        // gregorian rule from divisibility by 4, 16 and 25
        n_item.leap       = ((i_year[1:0] == 2'd0) && !n_div25) ||
                            ((i_year[3:0] == 4'd0) && n_div25);
        n_item.under      = 1'b0;
        n_item.bad_month  = (i_month == 4'd0) || (i_month > C_DEC);
        n_item.millis_raw = i_millis;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[hdl/utc_step.sv]
// ----------------------------------------------------------------------------
// utc_step
// one minute carry step: moves the ms total one minute toward 0..59999 and
// ripples the carry or borrow through minute, hour, day, month and year
// ----------------------------------------------------------------------------
module utc_step (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  utc_pkg::t_item i_item,
    output logic           o_valid,
    output utc_pkg::t_item o_item
);
    import utc_pkg::*;

    t_item n_item;
    logic  r_valid;
    t_item r_item;

    always_comb begin
        n_item = i_item;
        if (!i_item.bad_month && (i_item.total < 20'sd0)) begin
            n_item.total = i_item.total + C_MS_PER_MIN;
            if (i_item.minute != 6'd0) begin
                n_item.minute = i_item.minute - 6'd1;
            end else begin
                n_item.minute = C_LAST_MINUTE;
                if (i_item.hour != 5'd0) begin
                    n_item.hour = i_item.hour - 5'd1;
                end else begin
                    n_item.hour = C_LAST_HOUR;
                    if (i_item.day > 5'd1) begin
                        n_item.day = i_item.day - 5'd1;
                    end else begin
                        if (i_item.month > C_JAN) begin
                            n_item.month = i_item.month - 4'd1;
                        end else begin
                            n_item.month = C_DEC;
                            // borrow below year 0 sticks as underflow
                            if (i_item.year == 15'd0) begin
                                n_item.under = 1'b1;
                            end else begin
                                n_item.year = i_item.year - 15'd1;
                            end
                        end
                        n_item.day = f_mdays(i_item.leap, n_item.month);
                    end
                end
            end
        end else if (!i_item.bad_month && (i_item.total >= C_MS_PER_MIN)) begin
            n_item.total = i_item.total - C_MS_PER_MIN;
            if (i_item.minute < C_LAST_MINUTE) begin
                n_item.minute = i_item.minute + 6'd1;
            end else begin
                n_item.minute = 6'd0;
                if (i_item.hour < C_LAST_HOUR) begin
                    n_item.hour = i_item.hour + 5'd1;
                end else begin
                    n_item.hour = 5'd0;
                    if (i_item.day < f_mdays(i_item.leap, i_item.month)) begin
                        n_item.day = i_item.day + 5'd1;
                    end else begin
                        n_item.day = 5'd1;
                        if (i_item.month < C_DEC) begin
                            n_item.month = i_item.month + 4'd1;
                        end else begin
                            n_item.month = C_JAN;
                            n_item.year  = i_item.year + 15'd1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[hdl/utc_conv.sv]
// ----------------------------------------------------------------------------
// utc_conv
// nine stage back end: splits the ms total, turns the normalized date into
// days since the epoch and builds the saturated ms count
// ----------------------------------------------------------------------------
module utc_conv (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  utc_pkg::t_item     i_item,
    output logic               o_done,
    output logic [47:0]        o_epoch_ms,
    output logic signed [16:0] o_frac_ms,
    output logic               o_valid_res
);
    import utc_pkg::*;

    // stage valid bits
    logic [8:0] r_vld;

    // stage 1
    logic [15:0] n1_t;
    logic [32:0] n1_qprod;
    logic [3:0]  n1_mp;
    logic        n1_ok;
    logic [15:0] r1_t;
    logic [5:0]  r1_q;
    logic [14:0] r1_yy;
    logic [8:0]  r1_doy;
    logic [4:0]  r1_hour;
    logic [5:0]  r1_minute;
    logic        r1_ok;
    logic        r1_bad;
    logic [16:0] r1_raw;

    // stage 2
    logic [30:0] n2_eprod;
    logic [15:0] n2_ms;
    logic [6:0]  r2_era;
    logic [9:0]  r2_ms;
    logic [5:0]  r2_q;
    logic [14:0] r2_yy;
    logic [8:0]  r2_doy;
    logic [4:0]  r2_hour;
    logic [5:0]  r2_minute;
    logic        r2_ok;
    logic        r2_bad;
    logic [16:0] r2_raw;

    // stage 3
    logic [14:0] n3_yoe;
    logic [8:0]  r3_yoe;
    logic [23:0] r3_eraday;
    logic [16:0] r3_hms;
    logic [8:0]  r3_doy;
    logic [9:0]  r3_ms;
    logic        r3_ok;
    logic        r3_bad;
    logic [16:0] r3_raw;

    // stage 4
    logic [1:0]  n4_cent;
    logic [17:0] r4_doe;
    logic [23:0] r4_eraday;
    logic [16:0] r4_hms;
    logic [9:0]  r4_ms;
    logic        r4_ok;
    logic        r4_bad;
    logic [16:0] r4_raw;

    // stage 5
    logic [24:0] n5_days;
    logic [22:0] r5_days;
    logic [16:0] r5_hms;
    logic [9:0]  r5_ms;
    logic        r5_ok;
    logic        r5_bad;
    logic [16:0] r5_raw;

    // stage 6
    logic [39:0] r6_dsec;
    logic [16:0] r6_hms;
    logic [9:0]  r6_ms;
    logic        r6_ok;
    logic        r6_bad;
    logic [16:0] r6_raw;

    // stage 7
    logic [39:0] r7_secs;
    logic [9:0]  r7_ms;
    logic        r7_ok;
    logic        r7_bad;
    logic [16:0] r7_raw;

    // stage 8
    logic [49:0] n8_secs;
    logic [49:0] r8_prod;
    logic [9:0]  r8_ms;
    logic        r8_ok;
    logic        r8_bad;
    logic [16:0] r8_raw;

    // stage 9 (output)
    logic [50:0] n9_res;
    logic [47:0] n9_epoch;
    logic [47:0] r9_epoch;
    logic [16:0] r9_norm;
    logic        r9_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[7:0], i_valid};
        end
    end

    // stage 1: seconds from the ms total, march-based year and day of year
    always_comb begin
        n1_t     = i_item.total[15:0];
        n1_qprod = 33'(n1_t) * 33'(C_RECIP_1000);
        n1_mp    = (i_item.month > C_FEB) ? i_item.month - 4'd3 : i_item.month + 4'd9;
        n1_ok    = !i_item.bad_month && !i_item.under &&
                   (i_item.year >= C_EPOCH_YEAR) && (i_item.day != 5'd0);
    end

    always_ff @(posedge i_clk) begin
        r1_t      <= n1_t;
        r1_q      <= n1_qprod[31:26];
        r1_yy     <= i_item.year - 15'(i_item.month <= C_FEB);
        r1_doy    <= f_doy_base(n1_mp) + 9'(i_item.day) - 9'd1;
        r1_hour   <= i_item.hour;
        r1_minute <= i_item.minute;
        r1_ok     <= n1_ok;
        r1_bad    <= i_item.bad_month;
        r1_raw    <= i_item.millis_raw;
    end

    // stage 2: era and leftover ms
    always_comb begin
        n2_eprod = 31'(r1_yy) * 31'(C_RECIP_400);
        n2_ms    = r1_t - 16'(r1_q) * 16'(C_MS_PER_SEC);
    end

    always_ff @(posedge i_clk) begin
        r2_era    <= n2_eprod[30:24];
        r2_ms     <= n2_ms[9:0];
        r2_q      <= r1_q;
        r2_yy     <= r1_yy;
        r2_doy    <= r1_doy;
        r2_hour   <= r1_hour;
        r2_minute <= r1_minute;
        r2_ok     <= r1_ok;
        r2_bad    <= r1_bad;
        r2_raw    <= r1_raw;
    end

    // stage 3: year of era, era days, seconds within the day
    always_comb begin
        n3_yoe = r2_yy - 15'(r2_era) * 15'(C_YEARS_PER_ERA);
    end

    always_ff @(posedge i_clk) begin
        r3_yoe    <= n3_yoe[8:0];
        r3_eraday <= 24'(r2_era) * 24'(C_DAYS_PER_ERA);
        r3_hms    <= 17'(r2_hour) * 17'(C_SEC_PER_HOUR) +
                     17'(r2_minute) * 17'(C_SEC_PER_MIN) + 17'(r2_q);
        r3_doy    <= r2_doy;
        r3_ms     <= r2_ms;
        r3_ok     <= r2_ok;
        r3_bad    <= r2_bad;
        r3_raw    <= r2_raw;
    end

    // stage 4: day of era
    always_comb begin
        if (r3_yoe >= 9'd300) begin
            n4_cent = 2'd3;
        end else if (r3_yoe >= 9'd200) begin
            n4_cent = 2'd2;
        end else if (r3_yoe >= 9'd100) begin
            n4_cent = 2'd1;
        end else begin
            n4_cent = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_doe    <= 18'(r3_yoe) * 18'(C_DAYS_PER_YEAR) + 18'(r3_yoe[8:2]) -
                     18'(n4_cent) + 18'(r3_doy);
        r4_eraday <= r3_eraday;
        r4_hms    <= r3_hms;
        r4_ms     <= r3_ms;
        r4_ok     <= r3_ok;
        r4_bad    <= r3_bad;
        r4_raw    <= r3_raw;
    end

    // stage 5: days since the epoch
    always_comb begin
        n5_days = 25'(r4_eraday) + 25'(r4_doe) - 25'(C_EPOCH_DAY_OFS);
    end

    always_ff @(posedge i_clk) begin
        r5_days <= n5_days[22:0];
        r5_hms  <= r4_hms;
        r5_ms   <= r4_ms;
        r5_ok   <= r4_ok;
        r5_bad  <= r4_bad;
        r5_raw  <= r4_raw;
    end

    // stage 6: day seconds
    always_ff @(posedge i_clk) begin
        r6_dsec <= 40'(r5_days) * 40'(C_SEC_PER_DAY);
        r6_hms  <= r5_hms;
        r6_ms   <= r5_ms;
        r6_ok   <= r5_ok;
        r6_bad  <= r5_bad;
        r6_raw  <= r5_raw;
    end

    // stage 7: total seconds
    always_ff @(posedge i_clk) begin
        r7_secs <= r6_dsec + 40'(r6_hms);
        r7_ms   <= r6_ms;
        r7_ok   <= r6_ok;
        r7_bad  <= r6_bad;
        r7_raw  <= r6_raw;
    end

    // stage 8: seconds times 1000 as 1024 - 16 - 8
    always_comb begin
        n8_secs = 50'(r7_secs);
    end

    always_ff @(posedge i_clk) begin
        r8_prod <= (n8_secs << 10) - (n8_secs << 4) - (n8_secs << 3);
        r8_ms   <= r7_ms;
        r8_ok   <= r7_ok;
        r8_bad  <= r7_bad;
        r8_raw  <= r7_raw;
    end

    // stage 9: add ms, saturate, force zero on a rejected date
    always_comb begin
        n9_res = 51'(r8_prod) + 51'(r8_ms);
        if (!r8_ok) begin
            n9_epoch = '0;
        end else if (n9_res[50:48] != 3'd0) begin
            n9_epoch = '1;
        end else begin
            n9_epoch = n9_res[47:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r9_epoch <= n9_epoch;
        r9_norm  <= r8_bad ? r8_raw : 17'(r8_ms);
        r9_ok    <= r8_ok;
    end

    assign o_done      = r_vld[8];
    assign o_epoch_ms  = r9_epoch;
    assign o_frac_ms   = r9_norm;
    assign o_valid_res = r9_ok;

endmodule

[tb/sv/utc_epoch_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utc_epoch_checker
// watches the start and done channels of the epoch ms converter, computes
// the expected epoch ms, leftover ms and valid flag for every start transfer
// and compares them in order with the results the block delivers
// ----------------------------------------------------------------------------
module utc_epoch_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic [13:0]        i_year,
    input  logic [3:0]         i_month,
    input  logic [4:0]         i_day,
    input  logic [4:0]         i_hour,
    input  logic [5:0]         i_minute,
    input  logic [7:0]         i_second,
    input  logic signed [16:0] i_millis,
    input  logic [47:0]        i_epoch_ms,
    input  logic signed [16:0] i_frac_ms,
    input  logic               i_valid_res,
    input  logic               i_done,
    output int                 o_fail_count,
    output int                 o_pending
);
    import utc_pkg::*;

    localparam int          MS_PER_MINUTE = 60000;
    localparam int          MS_PER_SECOND = 1000;
    localparam int          FIRST_YEAR    = 1970;
    localparam longint      EPOCH_MAX     = 64'h0000_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [47:0]        epoch_ms;
        logic signed [16:0] norm_millis;
        logic               valid;
    } epoch_result_t;

    epoch_result_t expected_epochs[$];
    int            mismatches   = 0;
    int            results_seen = 0;
    int            pending_n    = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = pending_n;

    function automatic int month_days(input int yr, input int mon);
        bit leap_yr;
        int len;
        leap_yr = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
        case (mon) inside
            C_FEB:                      len = leap_yr ? 29 : 28;
            C_APR, C_JUN, C_SEP, C_NOV: len = 30;
            default:                    len = 31;
        endcase
        return len;
    endfunction

    function automatic epoch_result_t predict_epoch(
        input logic [13:0]        year,
        input logic [3:0]         month,
        input logic [4:0]         day,
        input logic [4:0]         hour,
        input logic [5:0]         minute,
        input logic [7:0]         second,
        input logic signed [16:0] millis
    );
        epoch_result_t r;
        int     y, mo, d, h, mi, total, sec, ms_part;
        int     yy, era, yoe, mp, doy, doe;
        bit     under;
        longint day_count, ms_count;
        r     = '0;
        under = 1'b0;
        y  = year;
        mo = month;
        d  = day;
        h  = hour;
        mi = minute;
        if (mo == 0 || mo > C_DEC) begin
            // bad month: nothing folded, millis passed through
            r.norm_millis = millis;
            return r;
        end
        total = int'(second) * MS_PER_SECOND + int'(millis);

        // borrow whole minutes, walking back through hour, day, month, year
        while (total < 0) begin
            total += MS_PER_MINUTE;
            if (mi > 0) begin
                mi--;
            end else begin
                mi = 59;
                if (h > 0) begin
                    h--;
                end else begin
                    h = 23;
                    if (d > 1) begin
                        d--;
                    end else begin
                        if (mo > C_JAN) begin
                            mo--;
                        end else begin
                            mo = C_DEC;
                            if (y == 0) under = 1'b1;
                            else        y--;
                        end
                        d = month_days(y, mo);
                    end
                end
            end
        end

        // carry whole minutes forward
        while (total >= MS_PER_MINUTE) begin
            total -= MS_PER_MINUTE;
            mi++;
            if (mi >= 60) begin
                mi = 0;
                h++;
                if (h >= 24) begin
                    h = 0;
                    d++;
                    if (d > month_days(y, mo)) begin
                        d = 1;
                        mo++;
                        if (mo > C_DEC) begin
                            mo = C_JAN;
                            y++;
                        end
                    end
                end
            end
        end

        sec           = total / MS_PER_SECOND;
        ms_part       = total % MS_PER_SECOND;
        r.norm_millis = ms_part[16:0];
        if (under || y < FIRST_YEAR || d == 0) return r;

        // days from civil date, march-based year
        yy  = y - ((mo <= C_FEB) ? 1 : 0);
        era = yy / 400;
        yoe = yy - era * 400;
        mp  = (mo > C_FEB) ? mo - 3 : mo + 9;
        doy = (153 * mp + 2) / 5 + d - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        day_count = longint'(era) * 146097 + longint'(doe) - 719468;
        ms_count  = (day_count * 86400 + longint'(h) * 3600 + longint'(mi) * 60
                     + longint'(sec)) * 1000 + longint'(ms_part);
        if (ms_count > EPOCH_MAX) ms_count = EPOCH_MAX;
        r.epoch_ms = ms_count[47:0];
        r.valid    = 1'b1;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: result %0d: %s", $time, results_seen, msg);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        epoch_result_t want;
        if (i_rst_n) begin
            if (i_done) begin
                if (expected_epochs.size() == 0) begin
                    report_mismatch("result with no conversion outstanding");
                end else begin
                    want = expected_epochs.pop_front();
                    if (i_epoch_ms !== want.epoch_ms)
                        report_mismatch($sformatf("epoch_ms got %0d want %0d",
                                                  i_epoch_ms, want.epoch_ms));
                    if (i_frac_ms !== want.norm_millis)
                        report_mismatch($sformatf("frac_ms got %0d want %0d",
                                                  i_frac_ms, want.norm_millis));
                    if (i_valid_res !== want.valid)
                        report_mismatch($sformatf("valid_res got %b want %b",
                                                  i_valid_res, want.valid));
                end
                results_seen++;
            end
            if (i_start && !i_busy)
                expected_epochs.push_back(predict_epoch(i_year, i_month, i_day, i_hour,
                                                        i_minute, i_second, i_millis));
        end
        pending_n <= expected_epochs.size();
    end

endmodule

[tb/sv/utc_date_time_to_epoch_ms_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utc_date_time_to_epoch_ms_tb
// drives dates and times into the epoch ms converter: a directed set of
// calendar corner cases, then random dates biased toward day, month and
// year rollovers in both directions, with random gaps between transfers;
// a separate checker predicts and compares every result
// ----------------------------------------------------------------------------
module utc_date_time_to_epoch_ms_tb;
    import utc_pkg::*;

    localparam int         RANDOM_ITEMS   = 1330;
    localparam int         STEADY_ITEMS   = 200;
    localparam int         DRAIN_POINT    = 600;
    localparam int         WATCHDOG_LIMIT = 1000;
    localparam logic [3:0] MONTH_NONE     = 4'd0;
    localparam logic [3:0] MONTH_OVER     = 4'd13;
    localparam logic [3:0] MONTH_TOP      = 4'd15;
    localparam logic [3:0] MONTH_MAR      = 4'd3;

    typedef struct packed {
        logic [13:0]        year;
        logic [3:0]         month;
        logic [4:0]         day;
        logic [4:0]         hour;
        logic [5:0]         minute;
        logic [7:0]         second;
        logic signed [16:0] millis;
    } date_item_t;

    logic               i_clk    = 1'b0;
    logic               i_rst_n  = 1'b0;
    logic               start    = 1'b0;
    logic               busy;
    logic [13:0]        i_year   = '0;
    logic [3:0]         i_month  = '0;
    logic [4:0]         i_day    = '0;
    logic [4:0]         i_hour   = '0;
    logic [5:0]         i_minute = '0;
    logic [7:0]         i_second = '0;
    logic signed [16:0] i_millis = '0;
    logic [47:0]        o_epoch_ms;
    logic signed [16:0] o_frac_ms;
    logic               o_valid_res;
    logic               o_done;
    int                 fail_count;
    int                 pending;
    int                 quiet_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    utc_date_time_to_epoch_ms DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_year      (i_year),
        .i_month     (i_month),
        .i_day       (i_day),
        .i_hour      (i_hour),
        .i_minute    (i_minute),
        .i_second    (i_second),
        .i_millis    (i_millis),
        .o_epoch_ms  (o_epoch_ms),
        .o_frac_ms   (o_frac_ms),
        .o_valid_res (o_valid_res),
        .o_done      (o_done)
    );

    utc_epoch_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_year       (i_year),
        .i_month      (i_month),
        .i_day        (i_day),
        .i_hour       (i_hour),
        .i_minute     (i_minute),
        .i_second     (i_second),
        .i_millis     (i_millis),
        .i_epoch_ms   (o_epoch_ms),
        .i_frac_ms    (o_frac_ms),
        .i_valid_res  (o_valid_res),
        .i_done       (o_done),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // cycles with neither a start transfer nor a result
    always @(posedge i_clk) begin
        if (i_rst_n && ((start && !busy) || o_done)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic date_item_t mk(input int y, input int mo, input int d, input int h,
                                      input int mi, input int s, input int ms);
        date_item_t it;
        it.year   = y[13:0];
        it.month  = mo[3:0];
        it.day    = d[4:0];
        it.hour   = h[4:0];
        it.minute = mi[5:0];
        it.second = s[7:0];
        it.millis = ms[16:0];
        return it;
    endfunction

    function automatic date_item_t make_random_date();
        date_item_t it;
        int mode, pick, v;
        mode = $urandom_range(0, 9);
        pick = $urandom_range(0, 9);
        if (pick < 6)      v = $urandom_range(1969, 2105);
        else if (pick < 8) v = $urandom_range(1890, 2410);
        else               v = $urandom_range(0, 16383);
        it.year = v[13:0];

        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            v = $urandom_range(0, 3);
            it.month = (v == 0) ? MONTH_NONE : 4'(MONTH_OVER + v - 1);
        end else if (pick < 5 && mode < 6) begin
            v = $urandom_range(0, 3);
            case (v)
                0:       it.month = C_JAN;
                1:       it.month = C_FEB;
                2:       it.month = MONTH_MAR;
                default: it.month = C_DEC;
            endcase
        end else begin
            it.month = 4'($urandom_range(1, 12));
        end

        if (mode < 3) begin
            // near the end of a day, pushed forward
            it.day    = 5'($urandom_range(27, 31));
            it.hour   = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(22, 31)) : C_LAST_HOUR;
            it.minute = 6'($urandom_range(58, 63));
            it.second = 8'($urandom_range(40, 255));
            v         = $urandom_range(0, 65535);
        end else if (mode < 6) begin
            // start of a day, pulled back
            it.day    = 5'($urandom_range(0, 2));
            it.hour   = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) : 5'd0;
            it.minute = 6'($urandom_range(0, 1));
            it.second = 8'($urandom_range(0, 5));
            v         = ($urandom_range(0, 1) == 0) ? -int'($urandom_range(1, 65536))
                                                    : -int'($urandom_range(1, 2000));
        end else begin
            it.day    = 5'($urandom_range(0, 31));
            it.hour   = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                    : 5'($urandom_range(0, 23));
            it.minute = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                    : 6'($urandom_range(0, 59));
            it.second = 8'($urandom_range(0, 255));
            v         = ($urandom_range(0, 1) == 0) ? int'($urandom_range(0, 2999)) - 1000
                                                    : int'($urandom_range(0, 131071));
        end
        it.millis = v[16:0];
        return it;
    endfunction

    // start stays high across back-to-back transfers
    task automatic send_date(input date_item_t it);
        start    <= 1'b1;
        i_year   <= it.year;
        i_month  <= it.month;
        i_day    <= it.day;
        i_hour   <= it.hour;
        i_minute <= it.minute;
        i_second <= it.second;
        i_millis <= it.millis;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic pause_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_all_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        date_item_t directed_q[$];
        int         gap_pct;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed_q.push_back(mk(1970, C_JAN, 1, 0, 0, 0, 0));
        directed_q.push_back(mk(1969, C_DEC, 31, 23, 59, 59, 1000));
        directed_q.push_back(mk(1970, C_JAN, 1, 0, 0, 0, -1));
        directed_q.push_back(mk(2020, MONTH_NONE, 5, 3, 4, 5, -65536));
        directed_q.push_back(mk(2020, MONTH_OVER, 5, 3, 4, 5, 65535));
        directed_q.push_back(mk(2020, MONTH_TOP, 31, 31, 63, 255, -1));
        directed_q.push_back(mk(2021, C_JUN, 0, 12, 30, 0, 0));
        // day zero pulled back into the last day of february
        directed_q.push_back(mk(2000, MONTH_MAR, 0, 0, 0, 0, -1));
        // day zero carried forward to the first
        directed_q.push_back(mk(2001, C_APR, 0, 23, 59, 60, 0));
        // borrow below year zero
        directed_q.push_back(mk(0, C_JAN, 1, 0, 0, 0, -1));
        directed_q.push_back(mk(2000, C_FEB, 28, 23, 59, 59, 1000));
        directed_q.push_back(mk(1900, C_FEB, 28, 23, 59, 59, 1000));
        directed_q.push_back(mk(2100, C_FEB, 28, 23, 59, 59, 1000));
        directed_q.push_back(mk(2024, MONTH_MAR, 1, 0, 0, 0, -65536));
        directed_q.push_back(mk(1999, C_DEC, 31, 23, 59, 59, 1000));
        // saturation at the top of the range
        directed_q.push_back(mk(16383, C_DEC, 31, 31, 63, 255, 65535));
        directed_q.push_back(mk(9999, C_DEC, 31, 23, 59, 59, 999));
        directed_q.push_back(mk(2038, C_JAN, 19, 3, 14, 255, 65535));
        directed_q.push_back(mk(2038, C_JAN, 19, 3, 14, 0, -65536));
        // out-of-range hour and minute used as given
        directed_q.push_back(mk(1985, C_NOV, 15, 31, 63, 10, 500));
        directed_q.push_back(mk(1995, C_APR, 31, 23, 59, 59, 1000));
        directed_q.push_back(mk(1995, C_SEP, 31, 12, 0, 0, 0));
        directed_q.push_back(mk(1990, C_JUN, 10, 10, 63, 59, 1000));
        directed_q.push_back(mk(1970, C_JAN, 0, 23, 59, 59, 1000));
        foreach (directed_q[k]) begin
            send_date(directed_q[k]);
            if ($urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 3));
        end
        wait_all_results();

        gap_pct = 30;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // alternate busy and gappy stretches
            if (n % 100 == 0) gap_pct = (gap_pct == 0) ? $urandom_range(10, 50) : 0;
            if (n == DRAIN_POINT) wait_all_results();
            send_date(make_random_date());
            if (n < RANDOM_ITEMS - STEADY_ITEMS && $urandom_range(0, 99) < gap_pct)
                pause_sender($urandom_range(1, 3));
        end

        wait_all_results();
        repeat (C_LATENCY + 5) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[utc_date_time_to_epoch_ms.f]
+incdir+hdl
hdl/utc_pkg.sv
hdl/utc_front.sv
hdl/utc_step.sv
hdl/utc_conv.sv
hdl/utc_date_time_to_epoch_ms.sv
tb/sv/utc_epoch_checker.sv
tb/sv/utc_date_time_to_epoch_ms_tb.sv
